FILE: hw/rtl/frame_scene_change_meter_defines.svh
// ----------------------------------------------------------------------------
// Scene change meter assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef FRAME_SCENE_CHANGE_METER_DEFINES_SVH
`define FRAME_SCENE_CHANGE_METER_DEFINES_SVH

// Same-cycle implication.
`define FSCM_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// Next-cycle implication.
`define FSCM_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

FILE: hw/rtl/fscm_pkg.sv
// ----------------------------------------------------------------------------
// Scene change meter package
// Field widths, luminance weights, register indexes and control state codes.
// ----------------------------------------------------------------------------
package fscm_pkg;

	localparam int PIXEL_W     = 16;
	localparam int LUMA_W      = 8;
	localparam int Q_W         = 16;
	localparam int USED_OUT_W  = 11;
	localparam int CFG_DATA_W  = 11;
	localparam int REG_IDX_W   = 1;
	localparam int SUM_W       = 32;
	localparam int WSUM_W      = 15;
	localparam int RECIP_W     = 13;
	localparam int PROD_W      = WSUM_W + RECIP_W;
	localparam int RECIP_SHIFT = 19;

	// 30/59/11 luminance weights, divide by 100 as multiply by 5243 / 2^19
	localparam logic [6:0]         LUMA_WR   = 7'd30;
	localparam logic [6:0]         LUMA_WG   = 7'd59;
	localparam logic [6:0]         LUMA_WB   = 7'd11;
	localparam logic [RECIP_W-1:0] RECIP_100 = 13'd5243;

	localparam logic [CFG_DATA_W-1:0] FRAME_WIDTH_RST = 11'd160;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_COLOR_MODE  = 1'b0,
		REG_FRAME_WIDTH = 1'b1
	} fscm_reg_t;

	typedef enum logic [2:0] {
		ST_RUN,
		ST_DRAIN,
		ST_LSTART,
		ST_LWAIT,
		ST_DSTART,
		ST_DWAIT,
		ST_OUT
	} fscm_state_t;

	// floor(c * 255 / 31): 8c plus the count of thresholds of 7c / 31
	function automatic logic [LUMA_W-1:0] expand5(input logic [4:0] c);
		logic [2:0] k;
		k = 3'(c >= 5'd5) + 3'(c >= 5'd9) + 3'(c >= 5'd14) + 3'(c >= 5'd18)
			+ 3'(c >= 5'd23) + 3'(c >= 5'd27) + 3'(c >= 5'd31);
		return {c, 3'b000} + 8'(k);
	endfunction

	// floor(c * 255 / 63): 4c plus floor(c / 21)
	function automatic logic [LUMA_W-1:0] expand6(input logic [5:0] c);
		logic [1:0] k;
		k = 2'(c >= 6'd21) + 2'(c >= 6'd42) + 2'(c >= 6'd63);
		return {c, 2'b00} + 8'(k);
	endfunction

endpackage

FILE: hw/rtl/fscm_in_if.sv
// ----------------------------------------------------------------------------
// Scene change meter pixel channel
// Valid/ready channel carrying one pixel word and its end-of-frame mark.
// ----------------------------------------------------------------------------
interface fscm_in_if;
	logic                         valid;
	logic                         ready;
	logic [fscm_pkg::PIXEL_W-1:0] pixel;
	logic                         frame_end;

	modport source (output valid, output pixel, output frame_end, input ready);
	modport sink (input valid, input pixel, input frame_end, output ready);
endinterface

FILE: hw/rtl/fscm_out_if.sv
// ----------------------------------------------------------------------------
// Scene change meter result channel
// Valid/ready channel carrying one per-frame statistics word.
// ----------------------------------------------------------------------------
interface fscm_out_if;
	logic                            valid;
	logic                            ready;
	logic [fscm_pkg::Q_W-1:0]        light_level;
	logic [fscm_pkg::Q_W-1:0]        scene_change;
	logic [fscm_pkg::USED_OUT_W-1:0] samples_used;

	modport source (output valid, output light_level, output scene_change,
		output samples_used, input ready);
	modport sink (input valid, input light_level, input scene_change,
		input samples_used, output ready);
endinterface

FILE: hw/rtl/fscm_div.sv
// ----------------------------------------------------------------------------
// Scene change meter divider
// Saturating Q0.16 restoring divider: floor(num * 2^16 / den), one bit a cycle.
// ----------------------------------------------------------------------------
module fscm_div #(
	parameter int DEN_W = 19
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [fscm_pkg::SUM_W-1:0] num,
	input  logic [DEN_W-1:0]           den,
	output logic                       done,
	output logic [fscm_pkg::Q_W-1:0]   quo
);

	localparam int CNT_W = $clog2(fscm_pkg::Q_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W-1:0] rem_q;
	logic [fscm_pkg::Q_W-1:0] quo_q;

	logic [DEN_W:0] trial;
	logic           ge;

	assign trial = {rem_q, 1'b0};
	assign ge    = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				// quotient of 2^16 or more: saturate at once
				if (num >= fscm_pkg::SUM_W'(den)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
					cnt_q  <= CNT_W'(fscm_pkg::Q_W);
				end
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			den_q <= den;
			rem_q <= DEN_W'(num);
			quo_q <= (num >= fscm_pkg::SUM_W'(den)) ? '1 : '0;
		end else if (busy_q) begin
			rem_q <= ge ? DEN_W'(trial - {1'b0, den_q}) : DEN_W'(trial);
			quo_q <= {quo_q[fscm_pkg::Q_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

FILE: hw/rtl/frame_scene_change_meter.sv
// ----------------------------------------------------------------------------
// Frame scene change meter
// Per-frame mean luminance and mean frame-to-frame difference of a pixel stream.
// ----------------------------------------------------------------------------
// Pixels arrive in raster order, one word per handshake, as 8-bit gray or
// RGB565 (color mode register); frame_width sets the row length, clamped to
// 1..MAX_WIDTH. Every STRIDE-th pixel of every STRIDE-th row is a sample.
// Each sample feeds the light sum; the first STORE_DEPTH samples of a frame
// are also compared with the same sample of the previous frame and written
// back to the sample store. The frame_end word yields one statistics word
// (light_level, scene_change, samples_used) if the frame held any sample.
// Within a frame the block takes one pixel per clock: a three-stage pipeline
// with the store read on acceptance and the write-back in stage three. After
// the frame_end word the input holds off for the pipeline drain, a 16-step
// light division in the shared restoring divider and, with a previous frame,
// a 16-step difference division (a saturating mean skips its steps); longer
// if the previous statistics word is not yet taken. The store needs no clearing
// pass: a fill count marks the entries written since reset; the rest read as zero.
// ----------------------------------------------------------------------------
`include "frame_scene_change_meter_defines.svh"

module frame_scene_change_meter #(
	parameter int STRIDE      = 4,
	parameter int STORE_DEPTH = 1200,
	parameter int MAX_WIDTH   = 1024
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [fscm_pkg::REG_IDX_W-1:0]       cfg_index,
	input  logic [fscm_pkg::CFG_DATA_W-1:0]      cfg_data,
	fscm_in_if.sink                              pixels,
	fscm_out_if.source                           stats
);

	// Derived widths
	localparam int PH_W   = (STRIDE > 1) ? $clog2(STRIDE) : 1;
	localparam int COL_W  = $clog2(MAX_WIDTH);
	localparam int WW     = ($clog2(MAX_WIDTH + 1) > fscm_pkg::CFG_DATA_W)
		? $clog2(MAX_WIDTH + 1) : fscm_pkg::CFG_DATA_W;
	localparam int USED_W = $clog2(STORE_DEPTH + 1);
	localparam int ADDR_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
	localparam int DEN_W  = USED_W + 8;
	localparam int LW     = fscm_pkg::LUMA_W;

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic                          fmt_q;
	logic [fscm_pkg::CFG_DATA_W-1:0] fwidth_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q    <= 1'b0;
			fwidth_q <= fscm_pkg::FRAME_WIDTH_RST;
		end else if (cfg_we) begin
			unique case (fscm_pkg::fscm_reg_t'(cfg_index))
				fscm_pkg::REG_COLOR_MODE:  fmt_q    <= cfg_data[0];
				fscm_pkg::REG_FRAME_WIDTH: fwidth_q <= cfg_data;
			endcase
		end
	end

	// Clamp the row length to 1..MAX_WIDTH
	logic [WW-1:0] width_eff;
	always_comb begin
		if (fwidth_q == '0) begin
			width_eff = WW'(1);
		end else if (WW'(fwidth_q) > WW'(MAX_WIDTH)) begin
			width_eff = WW'(MAX_WIDTH);
		end else begin
			width_eff = WW'(fwidth_q);
		end
	end

	// ------------------------------------------------------------------
	// Control state and handshake
	// ------------------------------------------------------------------
	fscm_pkg::fscm_state_t state_q, state_d;

	logic in_ready;
	logic in_acc;
	logic div_start;
	logic div_sel_diff;
	logic out_load;
	logic out_free;
	logic div_done;
	logic [fscm_pkg::Q_W-1:0] div_quo;

	assign pixels.ready = in_ready;
	assign in_acc       = pixels.valid && in_ready;

	// ------------------------------------------------------------------
	// Raster position and sample index
	// ------------------------------------------------------------------
	logic [COL_W-1:0]  col_q;
	logic [PH_W-1:0]   col_ph_q;
	logic [15:0]       row_q;
	logic [PH_W-1:0]   row_ph_q;
	logic [USED_W-1:0] idx_q;
	logic [USED_W-1:0] used_q;
	logic [USED_W-1:0] fill_q;

	logic              sample_now;
	logic              store_now;
	logic [USED_W-1:0] idx_next;
	logic [WW-1:0]     col_next;
	logic              col_wrap;
	logic [PH_W-1:0]   col_ph_next;
	logic [PH_W-1:0]   row_ph_next;
	logic [ADDR_W-1:0] rd_addr;

	assign sample_now  = (col_ph_q == '0) && (row_ph_q == '0);
	assign store_now   = sample_now && (idx_q < USED_W'(STORE_DEPTH));
	assign idx_next    = store_now ? idx_q + 1'b1 : idx_q;
	assign col_next    = WW'(col_q) + 1'b1;
	assign col_wrap    = col_next >= width_eff;
	assign col_ph_next = (col_ph_q == PH_W'(STRIDE - 1)) ? '0 : col_ph_q + 1'b1;
	// row counter wraps at 16 bits, and its phase restarts with it
	assign row_ph_next = (row_q == '1) ? '0
		: ((row_ph_q == PH_W'(STRIDE - 1)) ? '0 : row_ph_q + 1'b1);
	assign rd_addr     = ADDR_W'(idx_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			col_ph_q <= '0;
			row_q    <= '0;
			row_ph_q <= '0;
			idx_q    <= '0;
			used_q   <= '0;
		end else if (in_acc) begin
			if (pixels.frame_end) begin
				// capture the capped sample count, restart the raster
				used_q   <= idx_next;
				col_q    <= '0;
				col_ph_q <= '0;
				row_q    <= '0;
				row_ph_q <= '0;
				idx_q    <= '0;
			end else begin
				idx_q <= idx_next;
				if (col_wrap) begin
					col_q    <= '0;
					col_ph_q <= '0;
					row_q    <= row_q + 1'b1;
					row_ph_q <= row_ph_next;
				end else begin
					col_q    <= COL_W'(col_next);
					col_ph_q <= col_ph_next;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Pipeline: s1 store read + weights, s2 divide by 100, s3 write-back
	// ------------------------------------------------------------------
	logic s1_valid, s2_valid, s3_valid;

	logic [fscm_pkg::PIXEL_W-1:0] s1_pix;
	logic                         s1_fmt;
	logic                         s1_hit;
	logic                         s1_sample, s1_store, s1_last;
	logic [ADDR_W-1:0]            s1_addr;
	logic [LW-1:0]                rd_s1;

	logic [fscm_pkg::WSUM_W-1:0]  wsum_s2;
	logic [LW-1:0]                gray_s2;
	logic [LW-1:0]                prev_s2;
	logic                         fmt_s2;
	logic                         s2_sample, s2_store, s2_last;
	logic [ADDR_W-1:0]            s2_addr;

	logic [LW-1:0]                lum_s3;
	logic [LW-1:0]                prev_s3;
	logic                         s3_sample, s3_store, s3_last;
	logic [ADDR_W-1:0]            s3_addr;

	logic [LW-1:0] store_mem [STORE_DEPTH];

	logic [LW-1:0]                r8, g8, b8;
	logic [fscm_pkg::WSUM_W-1:0]  wsum_c;
	logic [fscm_pkg::PROD_W-1:0]  prod_c;
	logic [LW-1:0]                lum_c;
	logic                         mem_we;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
			s2_valid <= 1'b0;
			s3_valid <= 1'b0;
		end else begin
			s1_valid <= in_acc;
			s2_valid <= s1_valid;
			s3_valid <= s2_valid;
		end
	end

	// Sample store: read on acceptance, write back from stage three
	always_ff @(posedge clk) begin
		if (mem_we) begin
			store_mem[s3_addr] <= lum_s3;
		end
		if (in_acc && store_now) begin
			rd_s1 <= store_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			s1_pix    <= pixels.pixel;
			s1_fmt    <= fmt_q;
			// entries past the fill count were never written: read as zero
			s1_hit    <= idx_q < fill_q;
			s1_sample <= sample_now;
			s1_store  <= store_now;
			s1_last   <= pixels.frame_end;
			s1_addr   <= rd_addr;
		end
	end

	// Widen RGB565 channels and weight them
	assign r8     = fscm_pkg::expand5(s1_pix[15:11]);
	assign g8     = fscm_pkg::expand6(s1_pix[10:5]);
	assign b8     = fscm_pkg::expand5(s1_pix[4:0]);
	assign wsum_c = fscm_pkg::WSUM_W'(r8) * fscm_pkg::WSUM_W'(fscm_pkg::LUMA_WR)
		+ fscm_pkg::WSUM_W'(g8) * fscm_pkg::WSUM_W'(fscm_pkg::LUMA_WG)
		+ fscm_pkg::WSUM_W'(b8) * fscm_pkg::WSUM_W'(fscm_pkg::LUMA_WB);

	always_ff @(posedge clk) begin
		wsum_s2   <= wsum_c;
		gray_s2   <= s1_pix[LW-1:0];
		fmt_s2    <= s1_fmt;
		prev_s2   <= s1_hit ? rd_s1 : '0;
		s2_sample <= s1_sample;
		s2_store  <= s1_store;
		s2_last   <= s1_last;
		s2_addr   <= s1_addr;
	end

	// Exact floor(wsum / 100) for wsum up to 25500
	assign prod_c = fscm_pkg::PROD_W'(wsum_s2) * fscm_pkg::PROD_W'(fscm_pkg::RECIP_100);
	assign lum_c  = fmt_s2 ? prod_c[fscm_pkg::RECIP_SHIFT +: LW] : gray_s2;

	always_ff @(posedge clk) begin
		lum_s3    <= lum_c;
		prev_s3   <= prev_s2;
		s3_sample <= s2_sample;
		s3_store  <= s2_store;
		s3_last   <= s2_last;
		s3_addr   <= s2_addr;
	end

	// ------------------------------------------------------------------
	// Frame sums
	// ------------------------------------------------------------------
	logic [fscm_pkg::SUM_W-1:0] light_q;
	logic [DEN_W-1:0]           diff_q;
	logic                       prev_valid_q;

	logic [fscm_pkg::SUM_W:0]   light_add;
	logic [fscm_pkg::SUM_W-1:0] light_sat;
	logic [LW-1:0]              absd;
	logic [USED_W-1:0]          fill_cand;

	assign mem_we    = s3_valid && s3_store;
	assign light_add = {1'b0, light_q} + (fscm_pkg::SUM_W + 1)'(lum_s3);
	assign light_sat = light_add[fscm_pkg::SUM_W] ? '1 : light_add[fscm_pkg::SUM_W-1:0];
	assign absd      = (lum_s3 >= prev_s3) ? lum_s3 - prev_s3 : prev_s3 - lum_s3;
	assign fill_cand = USED_W'(s3_addr) + 1'b1;

	// Difference sum covers at most STORE_DEPTH samples of 255: never wraps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			light_q      <= '0;
			diff_q       <= '0;
			fill_q       <= '0;
			prev_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				light_q      <= '0;
				diff_q       <= '0;
				prev_valid_q <= 1'b1;
			end else begin
				if (s3_valid && s3_sample) begin
					light_q <= light_sat;
				end
				if (mem_we && prev_valid_q) begin
					diff_q <= diff_q + DEN_W'(absd);
				end
			end
			if (mem_we && (fill_cand > fill_q)) begin
				fill_q <= fill_cand;
			end
		end
	end

	// ------------------------------------------------------------------
	// Frame-end sequencer
	// ------------------------------------------------------------------
	assign out_free = !stats.valid || stats.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fscm_pkg::ST_RUN;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			fscm_pkg::ST_RUN: begin
				if (in_acc && pixels.frame_end) begin
					state_d = fscm_pkg::ST_DRAIN;
				end
			end
			fscm_pkg::ST_DRAIN: begin
				// frame with no sample: drop the result, keep the history flag
				if (s3_valid && s3_last) begin
					state_d = (used_q != '0) ? fscm_pkg::ST_LSTART : fscm_pkg::ST_RUN;
				end
			end
			fscm_pkg::ST_LSTART: state_d = fscm_pkg::ST_LWAIT;
			fscm_pkg::ST_LWAIT: begin
				if (div_done) begin
					state_d = prev_valid_q ? fscm_pkg::ST_DSTART : fscm_pkg::ST_OUT;
				end
			end
			fscm_pkg::ST_DSTART: state_d = fscm_pkg::ST_DWAIT;
			fscm_pkg::ST_DWAIT: begin
				if (div_done) begin
					state_d = fscm_pkg::ST_OUT;
				end
			end
			fscm_pkg::ST_OUT: begin
				if (out_free) begin
					state_d = fscm_pkg::ST_RUN;
				end
			end
			default: state_d = fscm_pkg::ST_RUN;
		endcase
	end

	always_comb begin
		in_ready     = 1'b0;
		div_start    = 1'b0;
		div_sel_diff = 1'b0;
		out_load     = 1'b0;
		unique case (state_q)
			fscm_pkg::ST_RUN:    in_ready = 1'b1;
			fscm_pkg::ST_LSTART: div_start = 1'b1;
			fscm_pkg::ST_DSTART: begin
				div_start    = 1'b1;
				div_sel_diff = 1'b1;
			end
			fscm_pkg::ST_OUT:    out_load = out_free;
			default: ;
		endcase
	end

	// ------------------------------------------------------------------
	// Shared divider: sum * 2^16 / (used * 255)
	// ------------------------------------------------------------------
	logic [fscm_pkg::SUM_W-1:0] div_num;
	logic [DEN_W-1:0]           div_den;

	assign div_num = div_sel_diff ? fscm_pkg::SUM_W'(diff_q) : light_q;
	assign div_den = {used_q, 8'h00} - DEN_W'(used_q);

	fscm_div #(
		.DEN_W (DEN_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	// ------------------------------------------------------------------
	// Results and output word
	// ------------------------------------------------------------------
	logic [fscm_pkg::Q_W-1:0]        light_res_q;
	logic [fscm_pkg::Q_W-1:0]        scene_res_q;
	logic                            out_valid_q;
	logic [fscm_pkg::Q_W-1:0]        light_out_q;
	logic [fscm_pkg::Q_W-1:0]        scene_out_q;
	logic [fscm_pkg::USED_OUT_W-1:0] used_out_q;

	always_ff @(posedge clk) begin
		if (state_q == fscm_pkg::ST_LWAIT && div_done) begin
			light_res_q <= div_quo;
			// first frame: no history, no scene change
			if (!prev_valid_q) begin
				scene_res_q <= '0;
			end
		end
		if (state_q == fscm_pkg::ST_DWAIT && div_done) begin
			scene_res_q <= div_quo;
		end
		if (out_load) begin
			light_out_q <= light_res_q;
			scene_out_q <= scene_res_q;
			used_out_q  <= fscm_pkg::USED_OUT_W'(used_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (stats.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign stats.valid        = out_valid_q;
	assign stats.light_level  = light_out_q;
	assign stats.scene_change = scene_out_q;
	assign stats.samples_used = used_out_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	`FSCM_ASSERT_IMP(a_last_drained, s3_valid && s3_last, !s1_valid && !s2_valid,
		"frame_end word reached write-back with pixels behind it")
	`FSCM_ASSERT_IMP(a_index_bound, 1'b1,
		idx_q <= USED_W'(STORE_DEPTH) && fill_q <= USED_W'(STORE_DEPTH),
		"sample index or fill count beyond store depth")
	`FSCM_ASSERT_IMP(a_div_done_wait, div_done,
		state_q == fscm_pkg::ST_LWAIT || state_q == fscm_pkg::ST_DWAIT,
		"divider finished outside a wait state")
	`FSCM_ASSERT_NXT(a_hold_after_last, in_acc && pixels.frame_end, !pixels.ready,
		"input taken before frame statistics were done")
	`FSCM_ASSERT_NXT(a_load_marks_history, out_load, stats.valid && prev_valid_q,
		"statistics word loaded without history flag")

endmodule
